[hw/rtl/threshold_wave_stretcher_defines.svh]
// Assertion macros for the threshold wave stretcher checker.
// No dependencies.
`ifndef THRESHOLD_WAVE_STRETCHER_DEFINES_SVH
`define THRESHOLD_WAVE_STRETCHER_DEFINES_SVH
`define TWS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TWS_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

[hw/rtl/tws_pkg.sv]
// Shared types for the threshold wave stretcher.
// No dependencies.
`timescale 1ns / 1ps
package tws_pkg;
  typedef enum logic [1:0] {
    BAND_INNER = 2'd0,
    BAND_HIGH  = 2'd1,
    BAND_LOW   = 2'd2,
    BAND_PASS  = 2'd3
  } band_e;
endpackage

[hw/rtl/tws_div_cell.sv]
// One restoring-division cell: while enabled, resolves one quotient bit per
// cycle and hands the partial remainder and side data to the next cell.
`timescale 1ns / 1ps
module tws_div_cell #(
  parameter int unsigned NW = 34,
  parameter int unsigned DW = 18,
  parameter int unsigned SW = 64,
  parameter int unsigned BIT = 0
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] rem_i,
  input  logic [NW-1:0] quo_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic [NW-1:0] rem_o,
  output logic [NW-1:0] quo_o,
  output logic [DW-1:0] den_o,
  output logic [SW-1:0] side_o
);
  logic [NW+DW-1:0] shifted;
  logic [NW+DW-1:0] trial;
  logic             fits;
  logic [NW-1:0]    rem_d, quo_d;

  always_comb begin
    shifted = {{DW{1'b0}}, den_i} << BIT;
    fits    = ({{DW{1'b0}}, rem_i} >= shifted);
    trial   = {{DW{1'b0}}, rem_i} - shifted;
    rem_d   = fits ? trial[NW-1:0] : rem_i;
    quo_d   = quo_i;
    quo_d[BIT] = fits;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= rem_d;
      quo_o  <= quo_d;
      den_o  <= den_i;
      side_o <= side_i;
    end
  end
endmodule

[hw/rtl/threshold_wave_stretcher.sv]
// Channel   | dir | tdata (low bit up)                      | end
// s_axis    | in  | sample_in, threshold_in, stretch_in      | tvalid/tready
// m_axis    | out | sample_out                              | tvalid/tready
// W = SAMPLE_BITS. One item per cycle sustained while the output is not stalled.
// The pipeline is the row of 2W+1 divider cells, one quotient bit each, plus
// the decode, numerator product and output stages.
// Reset clears the valid pipeline only. The whole row advances together; a
// stalled output holds it, and ready follows the output stage being free.
// Depends on tws_pkg and tws_div_cell.
`timescale 1ns / 1ps
module threshold_wave_stretcher #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // sample_in, threshold_in, stretch_in from bit 0 up
  input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // sample_out
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]   m_axis_tdata
);
  import tws_pkg::*;
  localparam int unsigned W   = SAMPLE_BITS;
  localparam int unsigned F   = W - 1;
  localparam int unsigned NW  = 2*W + 1;      // |numerator| bits
  localparam int unsigned DW  = W + 1;        // T, U
  localparam int unsigned NC  = NW;           // cells
  localparam int unsigned BW  = W + 2;        // base width
  localparam int unsigned SW  = BW + W + 2 + 1; // base, s, band, neg
  localparam int unsigned OW  = ((W+7)/8)*8;
  localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};

  logic adv;
  logic valid_q [NC+3];

  // Stage 0: decode, base product
  logic signed [W-1:0] x, c, s, cc;
  logic signed [W+1:0] tt, uu, twox, den_s, num_k;
  logic signed [W+1:0] sabs;
  logic signed [2*W+3:0] prod, numfull;
  logic signed [BW-1:0] base;
  band_e band;

  always_comb begin
    x = s_axis_tdata[W-1:0];
    c = s_axis_tdata[2*W-1:W];
    s = s_axis_tdata[3*W-1:2*W];
    cc = (c > CMAX) ? CMAX : ((c < -CMAX) ? -CMAX : c);
    tt = (W+2)'(cc) + (W+2)'(1 <<< F);
    uu = (W+2)'(2 <<< F) - tt;
    twox = (W+2)'(x) <<< 1;
    sabs = (s < 0) ? -(W+2)'(s) : (W+2)'(s);
    prod = (2*W+4)'(x) * (2*W+4)'((W+2)'(1 <<< F) - sabs);
    base = BW'(prod >>> F);
    if (s == 0) band = BAND_PASS;
    else if (twox < tt && twox > -tt) band = BAND_INNER;
    else if (twox >= tt) band = BAND_HIGH;
    else band = BAND_LOW;
    if (s > 0) begin
      num_k = twox;
      den_s = tt;
    end else begin
      num_k = (band == BAND_HIGH) ? twox - tt : twox + tt;
      den_s = uu;
    end
  end

  // Stage 1: decode registered; numerator product registered; division row
  logic [DW-1:0]        den_q;
  logic signed [W+1:0]  numk_q, sabs_q;
  logic [SW-1:0]        side_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      den_q  <= DW'(den_s);
      numk_q <= num_k;
      sabs_q <= sabs;
      side_q <= {base, s, band, 1'b0};
    end
  end

  logic [NW-1:0] rem [NC+1];
  logic [NW-1:0] quo [NC+1];
  logic [DW-1:0] den [NC+1];
  logic [SW-1:0] side[NC+1];
  logic [NW-1:0] rem1_q;
  logic [SW-1:0] side1_q;
  logic [DW-1:0] den1_q;
  logic signed [2*W+3:0] nf;
  logic nneg;

  always_comb begin
    nf   = (2*W+4)'(numk_q) * (2*W+4)'(sabs_q);
    nneg = nf < 0;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      rem1_q  <= nneg ? NW'(-nf) : NW'(nf);
      den1_q  <= den_q;
      side1_q <= {side_q[SW-1:1], nneg};
    end
  end
  assign rem[0]  = rem1_q;
  assign quo[0]  = '0;
  assign den[0]  = den1_q;
  assign side[0] = side1_q;

  for (genvar i = 0; i < NC; i++) begin : g_cell
    tws_div_cell #(.NW(NW), .DW(DW), .SW(SW), .BIT(NC-1-i)) u_cell (
      .clk_i (clk_i), .en_i (adv),
      .rem_i (rem[i]), .quo_i (quo[i]), .den_i (den[i]), .side_i (side[i]),
      .rem_o (rem[i+1]), .quo_o (quo[i+1]), .den_o (den[i+1]), .side_o (side[i+1])
    );
  end

  // Final: sign-correct floor quotient, sum, saturate; pass band keeps x
  logic signed [BW-1:0] fb;
  logic signed [W-1:0]  fs, fx;
  logic signed [NW+1:0] q, sum;
  logic                 fneg;
  logic [1:0]           fband_bits;
  band_e                fband;
  logic signed [W-1:0]  y_d;
  logic [OW-1:0]        out_q;

  always_comb begin
    {fb, fs, fband_bits, fneg} = side[NC];
    fband = band_e'(fband_bits);
    q = fneg ? -(NW+2)'(quo[NC]) - ((rem[NC] != '0) ? (NW+2)'(1) : (NW+2)'(0))
             : (NW+2)'(quo[NC]);
    sum = (NW+2)'(fb);
    fx  = W'(fb);
    if (fs > 0) begin
      if (fband == BAND_INNER) sum = sum + q;
      else if (fband == BAND_HIGH) sum = sum + (NW+2)'(fs);
      else sum = sum - (NW+2)'(fs);
    end else if (fband == BAND_HIGH || fband == BAND_LOW) begin
      sum = sum + q;
    end
    if (sum > (NW+2)'(CMAX)) y_d = CMAX;
    else if (sum < -(NW+2)'(CMAX) - 1) y_d = ~CMAX;
    else y_d = W'(sum);
    if (fband == BAND_PASS) y_d = fx;
  end

  // In pass band base = x since s = 0 gives prod = x << F.
  assign adv = !valid_q[NC+2] || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NC+3; k++) valid_q[k] <= 1'b0;
    end else if (adv) begin
      valid_q[0] <= s_axis_tvalid;
      for (int k = 1; k < NC+3; k++) valid_q[k] <= valid_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_q <= OW'($unsigned(y_d));
  end

  assign m_axis_tvalid = valid_q[NC+2];
  assign m_axis_tdata  = out_q;
endmodule

[hw/rtl/tws_checker.sv]
// Port-level checker for threshold_wave_stretcher, bound to the top level.
// Depends on threshold_wave_stretcher_defines.svh.
`timescale 1ns / 1ps
`include "threshold_wave_stretcher_defines.svh"
module tws_assertions (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready
);
  `TWS_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "output transaction dropped")
  `TWS_ASSERT(a_ready_free, clk_i, rst_ni, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output")
  `TWS_ASSERT(a_ready_stall, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |-> !s_axis_tready, "input taken while stalled")
  `TWS_ASSERT_RST(a_reset_empty, clk_i, !rst_ni |=> !m_axis_tvalid, "output valid in reset")
endmodule

bind threshold_wave_stretcher tws_assertions u_tws_checker (.*);

[verif/tws_checker.sv]
// Checker for the threshold wave stretcher: watches both stream channels,
// predicts each shaped sample and compares it with the block's output.
// Depends on nothing but the block's port widths.
`timescale 1ns / 1ps
module tws_checker #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  input  logic                                   s_axis_tready,
  // sample_in, threshold_in, stretch_in
  input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
  input  logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // sample_out
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       m_axis_tdata,
  output int                                     fail_count_o,
  output int                                     pending_o
);
  localparam int unsigned FB = SAMPLE_BITS - 1;
  localparam longint ONE = longint'(1) << FB;

  logic [SAMPLE_BITS-1:0] shaped_q[$];
  int fails_q = 0;

  function automatic longint fdiv(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] shape_sample(
    logic signed [SAMPLE_BITS-1:0] xs, logic signed [SAMPLE_BITS-1:0] cs,
    logic signed [SAMPLE_BITS-1:0] ss);
    longint x, c, s, tt, uu, twox, base, y, n;
    x = xs;
    c = cs;
    s = ss;
    if (s == 0) begin
      y = x;
    end else begin
      if (c > ONE - 1) c = ONE - 1;
      if (c < -(ONE - 1)) c = -(ONE - 1);
      tt = c + ONE;
      uu = 2 * ONE - tt;
      twox = 2 * x;
      n = (s > 0) ? s : -s;
      base = fdiv(x * (ONE - n), ONE);
      if (s > 0) begin
        if (twox < tt && twox > -tt) y = base + fdiv(twox * s, tt);
        else if (twox >= tt) y = base + s;
        else y = base - s;
      end else begin
        if (twox < tt && twox > -tt) y = base;
        else if (twox >= tt) y = base + fdiv((twox - tt) * n, uu);
        else y = base + fdiv((twox + tt) * n, uu);
      end
    end
    if (y > ONE - 1) y = ONE - 1;
    if (y < -ONE) y = -ONE;
    return y[SAMPLE_BITS-1:0];
  endfunction

  assign pending_o = shaped_q.size();
  assign fail_count_o = fails_q;

  always @(posedge clk_i) begin
    logic [SAMPLE_BITS-1:0] want, got;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        shaped_q.push_back(shape_sample(s_axis_tdata[SAMPLE_BITS-1:0],
          s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS],
          s_axis_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS]));
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[SAMPLE_BITS-1:0];
        if (shaped_q.size() == 0) begin
          fails_q <= fails_q + 1;
          $display("%0t: unexpected transaction, actual %0d", $time,
            $signed(got));
        end else begin
          want = shaped_q.pop_front();
          if (want !== got) begin
            fails_q <= fails_q + 1;
            $display("%0t: sample_out expected %0d actual %0d", $time,
              $signed(want), $signed(got));
          end
        end
      end
    end
  end
endmodule

[verif/tb.sv]
// Top of the threshold wave stretcher testbench: clock, reset, stimulus
// and verdict. Depends on threshold_wave_stretcher and tws_checker.
`timescale 1ns / 1ps
module tb;
  localparam int unsigned SB = 16;
  localparam int unsigned LATENCY = 2 * SB + 4;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  int fail_count;
  int pending;
  logic [15:0] dir_x[$];
  logic [15:0] dir_c[$];
  logic [15:0] dir_s[$];

  always #1 clk_i = ~clk_i;

  threshold_wave_stretcher #(.SAMPLE_BITS(SB)) u_dut (.*);

  tws_checker #(.SAMPLE_BITS(SB)) u_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Receiver stall pattern: phases of full, random and heavy backpressure.
  always @(posedge clk_i) begin
    int mode;
    mode = int'(($time / 400) % 3);
    if (mode == 0) m_axis_tready <= 1'b1;
    else if (mode == 1) m_axis_tready <= ($urandom_range(0, 3) != 0);
    else m_axis_tready <= ($urandom_range(0, 3) == 0);
  end

  function automatic logic [15:0] rand_field();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 7)) - 16'd3;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_item(logic [15:0] x, logic [15:0] c, logic [15:0] s);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {s, c, x};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  initial begin
    int gap;
    logic [15:0] cc;
    dir_x = '{16'h0000, 16'h7fff, 16'h8000, 16'h4000, 16'hc000, 16'h4000,
              16'hc000, 16'h3fff, 16'h7fff, 16'h8000, 16'h1234, 16'h7fff,
              16'h8000, 16'h0001, 16'hffff, 16'h2000, 16'he000, 16'h7fff,
              16'h8000, 16'h6000};
    dir_c = '{16'h0000, 16'h7fff, 16'h8000, 16'h0000, 16'h0000, 16'h0000,
              16'h0000, 16'h0000, 16'h8000, 16'h7fff, 16'h5555, 16'h0000,
              16'h0000, 16'h8000, 16'h7fff, 16'hc000, 16'h4000, 16'h8000,
              16'h7fff, 16'h0000};
    dir_s = '{16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
              16'h8000, 16'h4000, 16'h7fff, 16'h8000, 16'h0000, 16'h8000,
              16'h7fff, 16'h0001, 16'hffff, 16'hc000, 16'h4000, 16'h8000,
              16'h7fff, 16'h8001};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_x[i]) send_item(dir_x[i], dir_c[i], dir_s[i]);
    for (int n = 0; n < 750; n++) begin
      if (n == 300) begin
        // hold until the pipeline drains
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
      if ($urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 6);
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      cc = rand_field();
      // put the sample near the threshold now and then
      if ($urandom_range(0, 3) == 0)
        send_item(cc + 16'($urandom_range(0, 2)) - 16'd1, cc, rand_field());
      else
        send_item(rand_field(), cc, rand_field());
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #200000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
